[design/mf3_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_pkg: shared definitions for the 3x3 median filter
// Pixel type, size limits, register indexes, operation codes and the
// depth of the result queue.
// ----------------------------------------------------------------------------
package mf3_pkg;

   // One gray pixel.
   typedef logic [7:0] pixel_type;

   // Default size limits of the line stores and the row counter.
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 4096;

   // Smallest frame size in use; smaller register values are raised to it.
   localparam int MIN_SIZE = 3;

   // Value written for border pixels and drained outputs.
   localparam pixel_type BORDER_VALUE = 8'hFF;

   // Operation codes of the request channel.
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // Configuration registers.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;
   localparam int FW_W       = 11;
   localparam int FH_W       = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;
   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   // Result queue between the median pipeline and the response channel.
   localparam int RSP_DEPTH = 8;
   localparam int RSP_AW    = 3;

endpackage
`default_nettype wire

[design/mf3_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_req_if: request channel of the 3x3 median filter
// Carries one operation code and one pixel per transfer.
// ----------------------------------------------------------------------------
interface mf3_req_if;
   logic                valid;
   logic                ready;
   logic                op;
   mf3_pkg::pixel_type  pixel_value;

   modport source (output valid, output op, output pixel_value, input ready);
   modport sink   (input valid, input op, input pixel_value, output ready);
endinterface
`default_nettype wire

[design/mf3_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_rsp_if: response channel of the 3x3 median filter
// Carries one filtered pixel and the end-of-frame flag per transfer.
// ----------------------------------------------------------------------------
interface mf3_rsp_if;
   logic                valid;
   logic                ready;
   mf3_pkg::pixel_type  filtered_value;
   logic                frame_end;

   modport source (output valid, output filtered_value, output frame_end, input ready);
   modport sink   (input valid, input filtered_value, input frame_end, output ready);
endinterface
`default_nettype wire

[design/median_filter_3x3.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// median_filter_3x3: 3x3 median filter on a raster pixel stream
// Two line stores in block memory, a two-column window and a three-stage
// median network feed a small result queue.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on req in raster order (op = pixel) and one transfer may
// happen on every clock. The output frame leaves on rsp in raster order,
// frame_width + 1 positions behind the input: the first frame_width + 1
// pixels of a frame give no result. After the last pixel, send flush items
// (op = flush); each drains one trailing border output, the last of them
// carries frame_end. Flushes outside the drain and pixels during the drain
// are taken and dropped. Border outputs are 255.
// Results reach rsp through stages 1 to 3 and the result queue. The block
// takes one item per cycle; req.ready drops only when RSP_DEPTH results are
// in the pipeline or waiting in the result queue, so a stalled receiver
// stops the input after at most RSP_DEPTH further result-producing items.
// Reset empties the pipeline and queue, restarts the frame and loads the
// sizes 640 x 480; the line stores are not cleared, as every entry used for
// a median was written earlier in the same frame. A csr write also restarts
// the frame and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module median_filter_3x3 #(
   parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   mf3_req_if.sink                                req,
   mf3_rsp_if.source                              rsp,
   input  wire logic                              csr_write_enable,
   input  wire logic [mf3_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mf3_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int PW = $clog2(MAX_WIDTH + 2);
   localparam int AW = mf3_pkg::RSP_AW;

   // Small compare-exchange helpers for the median network.
   function automatic mf3_pkg::pixel_type min2(input mf3_pkg::pixel_type a,
                                               input mf3_pkg::pixel_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic mf3_pkg::pixel_type max2(input mf3_pkg::pixel_type a,
                                               input mf3_pkg::pixel_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic mf3_pkg::pixel_type med3(input mf3_pkg::pixel_type a,
                                               input mf3_pkg::pixel_type b,
                                               input mf3_pkg::pixel_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   // Configuration registers.
   logic [mf3_pkg::FW_W-1:0] frame_width_ff, frame_width_in;
   logic [mf3_pkg::FH_W-1:0] frame_height_ff, frame_height_in;

   // Raster position and drain counter.
   logic [XW-1:0] x_ff, x_in;
   logic [HW-1:0] y_ff, y_in;
   logic [PW-1:0] pending_ff, pending_in;

   // Sizes in use, clamped to the supported range.
   logic [WW-1:0] eff_w;
   logic [HW-1:0] eff_h;

   // Decode of the request transfer.
   logic          req_xfer;
   logic          rsp_xfer;
   logic          draining;
   logic          pixel_go;
   logic          flush_go;
   logic          token_go;
   logic [XW:0]   x_plus;
   logic [HW-1:0] y_plus;
   logic          wrap;

   // Line stores and their registered read data.
   mf3_pkg::pixel_type upper_mem [MAX_WIDTH];
   mf3_pkg::pixel_type middle_mem [MAX_WIDTH];
   mf3_pkg::pixel_type rd_upper_ff, rd_middle_ff;

   // Stage 1: read data back, window update and column sort.
   logic               s1_pix_valid_ff, s1_pix_valid_in;
   logic               s1_token_ff, s1_token_in;
   logic               s1_median_ff, s1_median_in;
   logic               s1_frame_end_ff, s1_frame_end_in;
   logic [XW-1:0]      s1_x_ff;
   mf3_pkg::pixel_type s1_pix_ff;
   mf3_pkg::pixel_type win_old_ff [3];
   mf3_pkg::pixel_type win_new_ff [3];
   mf3_pkg::pixel_type col_in [3][3];

   // Stage 2: sorted columns.
   logic               s2_token_ff, s2_median_ff, s2_frame_end_ff;
   mf3_pkg::pixel_type s2_col_ff [3][3];

   // Stage 3: low, middle and high candidates.
   logic               s3_token_ff, s3_median_ff, s3_frame_end_ff;
   mf3_pkg::pixel_type s3_lo_ff, s3_mid_ff, s3_hi_ff;
   mf3_pkg::pixel_type s3_value;

   // Result queue and credit count.
   mf3_pkg::pixel_type q_value_ff [mf3_pkg::RSP_DEPTH];
   logic               q_end_ff [mf3_pkg::RSP_DEPTH];
   logic [AW:0]        q_wr_ff, q_rd_ff;
   logic [AW:0]        credits_ff, credits_in;

   // Clamp the frame sizes.
   always_comb begin
      priority if (frame_width_ff < mf3_pkg::FW_W'(mf3_pkg::MIN_SIZE)) begin
         eff_w = WW'(mf3_pkg::MIN_SIZE);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(frame_width_ff);
      end
      priority if (frame_height_ff < mf3_pkg::FH_W'(mf3_pkg::MIN_SIZE)) begin
         eff_h = HW'(mf3_pkg::MIN_SIZE);
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         eff_h = HW'(MAX_HEIGHT);
      end else begin
         eff_h = HW'(frame_height_ff);
      end
   end

   // Handshakes and item decode.
   assign req.ready = (credits_ff < (AW + 1)'(mf3_pkg::RSP_DEPTH));
   assign req_xfer  = req.valid && req.ready;
   assign rsp_xfer  = rsp.valid && rsp.ready;
   assign draining  = (y_ff >= eff_h);
   assign pixel_go  = req_xfer && (req.op == mf3_pkg::OP_PIXEL) && !draining;
   assign flush_go  = req_xfer && (req.op == mf3_pkg::OP_FLUSH) && draining &&
                      (pending_ff != '0);
   assign x_plus    = {1'b0, x_ff} + (XW + 1)'(1);
   assign y_plus    = y_ff + HW'(1);
   assign wrap      = (x_plus >= (XW + 1)'(eff_w));

   // Outputs start at the second pixel of the second row; medians need two
   // rows and two columns of history.
   assign s1_pix_valid_in = pixel_go;
   assign s1_median_in    = (y_ff >= HW'(2)) && (x_ff >= XW'(2));
   assign s1_token_in     = flush_go ||
                            (pixel_go && ((y_ff >= HW'(2)) ||
                                          ((y_ff == HW'(1)) && (x_ff != '0))));
   assign s1_frame_end_in = flush_go && (pending_ff == PW'(1));
   assign token_go        = s1_token_in;

   // Position, drain counter and configuration.
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      pending_in      = pending_ff;
      priority if (csr_write_enable) begin
         unique case (csr_index)
            mf3_pkg::CSR_FRAME_WIDTH: begin
               frame_width_in = csr_write_data[mf3_pkg::FW_W-1:0];
            end
            mf3_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_in = csr_write_data[mf3_pkg::FH_W-1:0];
            end
         endcase
         x_in       = '0;
         y_in       = '0;
         pending_in = '0;
      end else if (flush_go) begin
         pending_in = pending_ff - PW'(1);
         if (pending_ff == PW'(1)) begin
            x_in = '0;
            y_in = '0;
         end
      end else if (pixel_go) begin
         if (wrap) begin
            x_in = '0;
            y_in = y_plus;
            if (y_plus >= eff_h) begin
               pending_in = PW'(eff_w) + PW'(1);
            end
         end else begin
            x_in = x_plus[XW-1:0];
         end
      end
   end

   // Credits count results accepted and not yet transferred out.
   always_comb begin
      credits_in = credits_ff;
      if (token_go && !rsp_xfer) begin
         credits_in = credits_ff + (AW + 1)'(1);
      end else if (!token_go && rsp_xfer) begin
         credits_in = credits_ff - (AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= mf3_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= mf3_pkg::FRAME_HEIGHT_RESET;
         x_ff            <= '0;
         y_ff            <= '0;
         pending_ff      <= '0;
         credits_ff      <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         x_ff            <= x_in;
         y_ff            <= y_in;
         pending_ff      <= pending_in;
         credits_ff      <= credits_in;
      end
   end

   // Line stores: read at the request transfer, written back in the cycle after
   // it, when the read data is available. Successive pixels use different
   // columns, so a write never meets a read of the same entry.
   always_ff @(posedge clock) begin
      if (pixel_go) begin
         rd_upper_ff <= upper_mem[x_ff];
      end
      if (s1_pix_valid_ff) begin
         upper_mem[s1_x_ff] <= rd_middle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pixel_go) begin
         rd_middle_ff <= middle_mem[x_ff];
      end
      if (s1_pix_valid_ff) begin
         middle_mem[s1_x_ff] <= s1_pix_ff;
      end
   end

   // Stage 1 registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_pix_valid_ff <= 1'b0;
         s1_token_ff     <= 1'b0;
      end else begin
         s1_pix_valid_ff <= s1_pix_valid_in;
         s1_token_ff     <= s1_token_in;
      end
      s1_median_ff    <= s1_median_in;
      s1_frame_end_ff <= s1_frame_end_in;
      s1_x_ff         <= x_ff;
      s1_pix_ff       <= req.pixel_value;
   end

   // The window shifts by one column for every pixel that reaches stage 1.
   always_ff @(posedge clock) begin
      if (s1_pix_valid_ff) begin
         win_old_ff    <= win_new_ff;
         win_new_ff[0] <= rd_upper_ff;
         win_new_ff[1] <= rd_middle_ff;
         win_new_ff[2] <= s1_pix_ff;
      end
   end

   // Sort each of the three window columns.
   always_comb begin
      mf3_pkg::pixel_type src [3][3];
      src[0] = win_old_ff;
      src[1] = win_new_ff;
      src[2][0] = rd_upper_ff;
      src[2][1] = rd_middle_ff;
      src[2][2] = s1_pix_ff;
      for (int c = 0; c < 3; c++) begin
         col_in[c][0] = min2(min2(src[c][0], src[c][1]), src[c][2]);
         col_in[c][1] = med3(src[c][0], src[c][1], src[c][2]);
         col_in[c][2] = max2(max2(src[c][0], src[c][1]), src[c][2]);
      end
   end

   // Stage 2 registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_token_ff <= 1'b0;
      end else begin
         s2_token_ff <= s1_token_ff;
      end
      s2_median_ff    <= s1_median_ff;
      s2_frame_end_ff <= s1_frame_end_ff;
      s2_col_ff       <= col_in;
   end

   // Stage 3: largest minimum, median of medians, smallest maximum.
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_token_ff <= 1'b0;
      end else begin
         s3_token_ff <= s2_token_ff;
      end
      s3_median_ff    <= s2_median_ff;
      s3_frame_end_ff <= s2_frame_end_ff;
      s3_lo_ff  <= max2(max2(s2_col_ff[0][0], s2_col_ff[1][0]), s2_col_ff[2][0]);
      s3_mid_ff <= med3(s2_col_ff[0][1], s2_col_ff[1][1], s2_col_ff[2][1]);
      s3_hi_ff  <= min2(min2(s2_col_ff[0][2], s2_col_ff[1][2]), s2_col_ff[2][2]);
   end

   // The median of the nine is the median of the three candidates.
   assign s3_value = s3_median_ff ? med3(s3_lo_ff, s3_mid_ff, s3_hi_ff)
                                  : mf3_pkg::BORDER_VALUE;

   // Result queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff <= '0;
         q_rd_ff <= '0;
      end else begin
         if (s3_token_ff) begin
            q_wr_ff <= q_wr_ff + (AW + 1)'(1);
         end
         if (rsp_xfer) begin
            q_rd_ff <= q_rd_ff + (AW + 1)'(1);
         end
      end
      if (s3_token_ff) begin
         q_value_ff[q_wr_ff[AW-1:0]] <= s3_value;
         q_end_ff[q_wr_ff[AW-1:0]]   <= s3_frame_end_ff;
      end
   end

   assign rsp.valid          = (q_wr_ff != q_rd_ff);
   assign rsp.filtered_value = q_value_ff[q_rd_ff[AW-1:0]];
   assign rsp.frame_end      = q_end_ff[q_rd_ff[AW-1:0]];

endmodule
`default_nettype wire

[design/mf3_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_checker: port-level checks for the 3x3 median filter
// Watches the request and response channels and reports violations.
// ----------------------------------------------------------------------------
module mf3_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire mf3_pkg::pixel_type  rsp_filtered_value,
   input wire logic                rsp_frame_end
);

   // A response that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped before the transfer");

   // Reset empties the result queue.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // A response appearing on an empty queue comes from a request taken
   // earlier that passed the pipeline stages and the queue write.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 4))
      else $error("response without a request four cycles earlier");

   // The last output of a frame is a drained border pixel.
   a_end_border: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_filtered_value == mf3_pkg::BORDER_VALUE)
      else $error("frame end on a non-border output");

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req.valid),
   .req_ready          (req.ready),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_filtered_value (rsp.filtered_value),
   .rsp_frame_end      (rsp.frame_end)
);
`default_nettype wire
